// ===== sv/rrq_pkg.sv =====
// rrq_pkg: shared constants, types and helper functions for rect_range_extreme_query
// no dependencies
package rrq_pkg;

  localparam int MAX_ROWS_DEF   = 32;
  localparam int MAX_COLS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 6;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAKE_MAX = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS     = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;    // capture input item
    logic issue_read;   // issue read of read address
    logic issue_write;  // write combined value
    logic acc_clear;    // first operand of combine
    logic acc_take;     // combine read data into accumulator
    logic out_valid;    // drive result strobe
    logic out_bad;      // flagged result
  } rrq_cmd_t;

  function automatic int clog2_min1(input int n);
    int r;
    r = 0;
    while ((1 << r) < n) r++;
    return (r < 1) ? 1 : r;
  endfunction

  function automatic int lvls(input int n);
    int r;
    r = 1;
    while ((1 << r) <= n) r++;
    return r;
  endfunction

endpackage

// ===== sv/rrq_ctrl.sv =====
// rrq_ctrl: controller state machine for rect_range_extreme_query
// sequences table rebuild and four-block query; depends on rrq_pkg
module rrq_ctrl #(
  parameter int MAX_ROWS = rrq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rrq_pkg::MAX_COLS_DEF,
  parameter int RB = rrq_pkg::clog2_min1(rrq_pkg::MAX_ROWS_DEF + 1),
  parameter int CB = rrq_pkg::clog2_min1(rrq_pkg::MAX_COLS_DEF + 1),
  parameter int XB = rrq_pkg::clog2_min1(rrq_pkg::lvls(rrq_pkg::MAX_ROWS_DEF)),
  parameter int YB = rrq_pkg::clog2_min1(rrq_pkg::lvls(rrq_pkg::MAX_COLS_DEF))
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic mode,
  input  logic in_grid,
  input  logic bad,
  input  logic stale,
  input  logic [RB-1:0] n_rows,
  input  logic [CB-1:0] n_cols,
  input  logic [XB-1:0] ln,
  input  logic [YB-1:0] lm,
  input  logic [RB-1:0] q_r1,
  input  logic [CB-1:0] q_c1,
  input  logic [RB-1:0] q_rb,
  input  logic [CB-1:0] q_cr,
  input  logic [XB-1:0] q_x,
  input  logic [YB-1:0] q_y,
  output logic busy,
  output logic clear_stale,
  output logic set_stale_load,
  output rrq_pkg::rrq_cmd_t cmd,
  output logic [RB-1:0] rd_i,
  output logic [CB-1:0] rd_j,
  output logic [XB-1:0] rd_x,
  output logic [YB-1:0] rd_y,
  output logic [RB-1:0] wr_i,
  output logic [CB-1:0] wr_j,
  output logic [XB-1:0] wr_x,
  output logic [YB-1:0] wr_y
);
  import rrq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_BLD  = 3'd2;
  localparam logic [2:0] S_QRY  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [1:0] P_ROW  = 2'd0;
  localparam logic [1:0] P_COL  = 2'd1;
  localparam logic [1:0] P_BOTH = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [RB-1:0] i, i_next;
  logic [CB-1:0] j, j_next;
  logic [XB-1:0] x, x_next;
  logic [YB-1:0] y, y_next;
  logic [1:0] k, k_next;
  logic [2:0] pend, pend_next;

  logic [RB:0] i_half, i_end;
  logic [CB:0] j_half, j_end;
  logic row_fit, col_fit;

  assign busy = (state != S_IDLE);

  always_comb begin
    i_half = {1'b0, i} + ((RB+1)'(1) << x) - ((RB+1)'(1) << x) / 2;
    j_half = {1'b0, j} + ((CB+1)'(1) << y) - ((CB+1)'(1) << y) / 2;
    i_end  = {1'b0, i} + ((RB+1)'(1) << x);
    j_end  = {1'b0, j} + ((CB+1)'(1) << y);
    row_fit = (i_end <= {1'b0, n_rows});
    col_fit = (j_end <= {1'b0, n_cols});
  end

  always_comb begin
    cmd = '0;
    clear_stale = 1'b0;
    set_stale_load = 1'b0;
    state_next = state;
    phase_next = phase;
    i_next = i; j_next = j; x_next = x; y_next = y;
    k_next = k; pend_next = {pend[1:0], 1'b0};
    rd_i = i; rd_j = j; rd_x = x; rd_y = y;
    wr_i = i; wr_j = j; wr_x = x; wr_y = y;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (mode == MODE_LOAD) begin
          cmd.issue_write = 1'b1;
          set_stale_load = in_grid;
          state_next = S_IDLE;
        end else if (bad) begin
          cmd.out_valid = 1'b1;
          cmd.out_bad = 1'b1;
          state_next = S_IDLE;
        end else if (stale) begin
          phase_next = P_ROW;
          i_next = '0; j_next = '0; x_next = '0; y_next = YB'(1);
          k_next = '0;
          state_next = S_BLD;
        end else begin
          k_next = '0;
          state_next = S_QRY;
        end
      end
      S_BLD: begin
        // one block per step: issue reads (2 or 4), wait, combine, write
        if (!(row_fit && col_fit) || (phase != P_COL && y > lm) ||
            (phase != P_ROW && x > ln)) begin
          // advance loop indices without work; in the combined pass, end the rebuild
          if (phase == P_ROW) begin
            if (y > lm || i >= n_rows) begin
              phase_next = P_COL; i_next = '0; j_next = '0;
              x_next = XB'(1); y_next = '0;
            end else if (!col_fit) begin
              j_next = '0;
              if (y == lm) begin y_next = YB'(1); i_next = i + RB'(1); end
              else y_next = y + YB'(1);
            end
          end else if (phase == P_COL) begin
            if (x > ln || j >= n_cols) begin
              phase_next = P_BOTH; i_next = '0; j_next = '0;
              x_next = XB'(1); y_next = YB'(1);
            end else if (!row_fit) begin
              i_next = '0;
              if (x == ln) begin x_next = XB'(1); j_next = j + CB'(1); end
              else x_next = x + XB'(1);
            end
          end else begin
            if (x > ln || lm == '0) begin
              clear_stale = 1'b1;
              k_next = '0;
              state_next = S_QRY;
            end else if (!row_fit) begin
              x_next = x + XB'(1); i_next = '0; y_next = YB'(1); j_next = '0;
            end else if (y > lm) begin
              i_next = i + RB'(1); y_next = YB'(1); j_next = '0;
            end else begin
              j_next = '0; y_next = y + YB'(1);
            end
          end
        end else begin
          rd_x = (phase == P_ROW) ? x : x - XB'(1);
          rd_y = (phase == P_COL) ? y : y - YB'(1);
          rd_i = (k[1] && phase != P_ROW) ? i_half[RB-1:0] : i;
          rd_j = ((phase == P_ROW && k[0]) || (phase == P_BOTH && k[0])) ?
                 j_half[CB-1:0] : j;
          if (phase == P_COL) rd_i = k[0] ? i_half[RB-1:0] : i;
          if (pend == '0 && k_next == k) begin
            if (k == 2'd3 || (phase != P_BOTH && k == 2'd1) || k[1] == 1'b0 ||
                phase == P_BOTH) begin
              cmd.issue_read = 1'b1;
              pend_next = {pend[1:0], 1'b1};
              if ((phase != P_BOTH && k == 2'd1) || k == 2'd3) k_next = 2'd0;
              else k_next = k + 2'd1;
            end
          end
          if (pend[1]) cmd.acc_take = 1'b1;
          // last read of block issued at last k; write after its data
          if (pend[2] && k == 2'd0 && pend[1:0] == 2'b00) begin
            cmd.issue_write = 1'b1;
            if (phase == P_ROW) j_next = j + CB'(1);
            else if (phase == P_COL) i_next = i + RB'(1);
            else j_next = j + CB'(1);
          end
        end
      end
      S_QRY: begin
        rd_x = q_x; rd_y = q_y;
        rd_i = k[1] ? q_rb : q_r1;
        rd_j = k[0] ? q_cr : q_c1;
        if (pend[2:0] == '0 || k != 2'd0) begin
          if (!(k == 2'd0 && pend != '0)) begin
            cmd.issue_read = 1'b1;
            pend_next = {pend[1:0], 1'b1};
            k_next = k + 2'd1;
          end
        end
        if (pend[1]) cmd.acc_take = 1'b1;
        if (pend[2] && pend[1:0] == 2'b00 && k == 2'd0) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_valid = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    cmd.acc_clear = cmd.issue_read && (k == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_ROW;
      i <= '0; j <= '0; x <= '0; y <= '0; k <= '0; pend <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      i <= i_next; j <= j_next; x <= x_next; y <= y_next;
      k <= k_next; pend <= pend_next;
    end
  end

endmodule

// ===== sv/rrq_datapath.sv =====
// rrq_datapath: table memory, query decode and combine unit for rect_range_extreme_query
// depends on rrq_pkg
module rrq_datapath #(
  parameter int MAX_ROWS = rrq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rrq_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = rrq_pkg::VALUE_BITS_DEF,
  parameter int RB = rrq_pkg::clog2_min1(rrq_pkg::MAX_ROWS_DEF + 1),
  parameter int CB = rrq_pkg::clog2_min1(rrq_pkg::MAX_COLS_DEF + 1),
  parameter int XB = rrq_pkg::clog2_min1(rrq_pkg::lvls(rrq_pkg::MAX_ROWS_DEF)),
  parameter int YB = rrq_pkg::clog2_min1(rrq_pkg::lvls(rrq_pkg::MAX_COLS_DEF))
) (
  input  logic clk,
  input  logic rst,
  input  rrq_pkg::rrq_cmd_t cmd,
  input  logic mode,
  input  logic [4:0] top_row,
  input  logic [4:0] left_col,
  input  logic [4:0] bottom_row,
  input  logic [4:0] right_col,
  input  logic signed [31:0] cell_value,
  input  logic cfg_max,
  input  logic [RB-1:0] n_rows,
  input  logic [CB-1:0] n_cols,
  input  logic [RB-1:0] rd_i,
  input  logic [CB-1:0] rd_j,
  input  logic [XB-1:0] rd_x,
  input  logic [YB-1:0] rd_y,
  input  logic [RB-1:0] wr_i,
  input  logic [CB-1:0] wr_j,
  input  logic [XB-1:0] wr_x,
  input  logic [YB-1:0] wr_y,
  output logic q_mode,
  output logic in_grid,
  output logic bad,
  output logic [XB-1:0] ln,
  output logic [YB-1:0] lm,
  output logic [RB-1:0] q_r1,
  output logic [CB-1:0] q_c1,
  output logic [RB-1:0] q_rb,
  output logic [CB-1:0] q_cr,
  output logic [XB-1:0] q_x,
  output logic [YB-1:0] q_y,
  output logic signed [31:0] extreme_value,
  output logic bad_rectangle,
  output logic result_strobe
);
  import rrq_pkg::*;

  localparam int RL = lvls(MAX_ROWS);
  localparam int CL = lvls(MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS * RL * CL;
  localparam int AB = clog2_min1(DEPTH);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata, acc, wdata;
  logic [AB-1:0] raddr, waddr;
  logic [4:0] r1, c1, r2, c2;
  logic signed [31:0] val;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      q_mode <= mode; r1 <= top_row; c1 <= left_col;
      r2 <= bottom_row; c2 <= right_col; val <= cell_value;
    end
  end

  function automatic int flog2(input logic [RB+CB:0] v);
    int r;
    r = 0;
    for (int b = 1; b <= RB + CB; b++) if (v >= (RB+CB+1)'(1) << b) r = b;
    return r;
  endfunction

  logic [5:0] hgt, wid;
  always_comb begin
    in_grid = (32'(r1) < MAX_ROWS) && (32'(c1) < MAX_COLS);
    bad = (r1 > r2) || (c1 > c2) || ({1'b0, r2} >= 6'(n_rows)) ||
          ({1'b0, c2} >= 6'(n_cols));
    ln = XB'(flog2((RB+CB+1)'(n_rows)));
    lm = YB'(flog2((RB+CB+1)'(n_cols)));
    hgt = 6'(r2) - 6'(r1) + 6'd1;
    wid = 6'(c2) - 6'(c1) + 6'd1;
    q_x = XB'(flog2((RB+CB+1)'(hgt)));
    q_y = YB'(flog2((RB+CB+1)'(wid)));
    q_r1 = RB'(r1);
    q_c1 = CB'(c1);
    q_rb = RB'(6'(r2) + 6'd1 - (6'd1 << q_x));
    q_cr = CB'(6'(c2) + 6'd1 - (6'd1 << q_y));
  end

  function automatic logic [AB-1:0] slot(input logic [RB-1:0] i, input logic [CB-1:0] j,
                                         input logic [XB-1:0] x, input logic [YB-1:0] y);
    return AB'(((32'(i) * MAX_COLS + 32'(j)) * RL + 32'(x)) * CL + 32'(y));
  endfunction

  assign raddr = slot(rd_i, rd_j, rd_x, rd_y);
  assign waddr = (q_mode == MODE_LOAD) ? slot(RB'(r1), CB'(c1), '0, '0)
                                       : slot(wr_i, wr_j, wr_x, wr_y);
  assign wdata = (q_mode == MODE_LOAD) ? VALUE_BITS'(val) : acc;

  logic rv1, rv2, first1, first2;
  logic [VALUE_BITS-1:0] rd_q;
  always_ff @(posedge clk) begin
    if (cmd.issue_write && (q_mode != MODE_LOAD || in_grid)) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
    rdata <= rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv1 <= 1'b0; rv2 <= 1'b0; first1 <= 1'b0; first2 <= 1'b0;
    end else begin
      rv1 <= cmd.issue_read; rv2 <= rv1;
      first1 <= cmd.acc_clear; first2 <= first1;
    end
  end

  logic gt;
  assign gt = $signed(rdata) > $signed(acc);
  always_ff @(posedge clk) begin
    if (cmd.acc_take && rv2) begin
      if (first2 || (cfg_max ? gt : ($signed(rdata) < $signed(acc)))) acc <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      bad_rectangle <= 1'b0;
      extreme_value <= '0;
    end else begin
      result_strobe <= cmd.out_valid;
      bad_rectangle <= cmd.out_bad;
      extreme_value <= cmd.out_bad ? '0 : 32'(acc);
    end
  end

endmodule

// ===== sv/rect_range_extreme_query.sv =====
// rect_range_extreme_query: top level, config registers, controller and datapath
// depends on rrq_pkg, rrq_ctrl, rrq_datapath
//
// usage: pulse start with the item fields while busy is low. mode 0 loads one
// grid cell (no result), mode 1 queries a rectangle and gives one result on
// extreme_value / bad_rectangle marked by result_strobe for one cycle.
// configuration: cfg_we, cfg_index, cfg_data write one register per cycle.
// a load returns to idle after decode; a flagged query gives its result from
// decode. a query on a fresh table reads four blocks from the table memory's
// single read port, one read every cycle, then gives its strobe; the next item
// can be taken once busy is low. the first query after a load or a write to one
// of the three registers first rebuilds the block table, two reads per block in
// the row and column passes and four in the combined pass; busy stays high
// meanwhile. reset: registers return to maximum, 32 rows, 32 columns; table
// marked stale. the table memory is not cleared; every cell must be loaded by
// the user before the first query, and the block itself does not enforce it.
// the receiver cannot stall: each result is shown for exactly one cycle.
module rect_range_extreme_query #(
  parameter int MAX_ROWS = rrq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rrq_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = rrq_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic mode,
  input  logic [4:0] top_row,
  input  logic [4:0] left_col,
  input  logic [4:0] bottom_row,
  input  logic [4:0] right_col,
  input  logic signed [31:0] cell_value,
  input  logic cfg_we,
  input  logic [rrq_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rrq_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic result_strobe,
  output logic signed [31:0] extreme_value,
  output logic bad_rectangle
);
  import rrq_pkg::*;

  localparam int RB = clog2_min1(MAX_ROWS + 1);
  localparam int CB = clog2_min1(MAX_COLS + 1);
  localparam int XB = clog2_min1(lvls(MAX_ROWS));
  localparam int YB = clog2_min1(lvls(MAX_COLS));

  logic take_maximum, stale;
  logic [RB-1:0] n_rows;
  logic [CB-1:0] n_cols;
  logic clear_stale, set_stale_load, q_mode, in_grid, bad;
  rrq_cmd_t cmd;
  logic [XB-1:0] ln, q_x, rd_x, wr_x;
  logic [YB-1:0] lm, q_y, rd_y, wr_y;
  logic [RB-1:0] q_r1, q_rb, rd_i, wr_i;
  logic [CB-1:0] q_c1, q_cr, rd_j, wr_j;

  function automatic logic [RB-1:0] clamp_r(input logic [5:0] v);
    if (v == '0) return RB'(1);
    if (32'(v) > MAX_ROWS) return RB'(MAX_ROWS);
    return RB'(v);
  endfunction
  function automatic logic [CB-1:0] clamp_c(input logic [5:0] v);
    if (v == '0) return CB'(1);
    if (32'(v) > MAX_COLS) return CB'(MAX_COLS);
    return CB'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      take_maximum <= 1'b1;
      n_rows <= clamp_r(6'd32);
      n_cols <= clamp_c(6'd32);
      stale <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TAKE_MAX: take_maximum <= cfg_data[0];
          REG_ROWS:     n_rows <= clamp_r(cfg_data);
          REG_COLS:     n_cols <= clamp_c(cfg_data);
          default: ;
        endcase
      end
      if (clear_stale) stale <= 1'b0;
      if (set_stale_load ||
          (cfg_we && (cfg_index inside {REG_TAKE_MAX, REG_ROWS, REG_COLS}))) stale <= 1'b1;
    end
  end

  rrq_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .RB(RB), .CB(CB),
             .XB(XB), .YB(YB)) u_ctrl (
    .clk, .rst, .start, .mode(q_mode), .in_grid, .bad, .stale, .n_rows, .n_cols,
    .ln, .lm, .q_r1, .q_c1, .q_rb, .q_cr, .q_x, .q_y, .busy, .clear_stale,
    .set_stale_load, .cmd, .rd_i, .rd_j, .rd_x, .rd_y, .wr_i, .wr_j, .wr_x, .wr_y
  );

  rrq_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .VALUE_BITS(VALUE_BITS),
                 .RB(RB), .CB(CB), .XB(XB), .YB(YB)) u_dp (
    .clk, .rst, .cmd, .mode, .top_row, .left_col, .bottom_row, .right_col,
    .cell_value, .cfg_max(take_maximum), .n_rows, .n_cols, .rd_i, .rd_j, .rd_x,
    .rd_y, .wr_i, .wr_j, .wr_x, .wr_y, .q_mode, .in_grid, .bad, .ln, .lm, .q_r1,
    .q_c1, .q_rb, .q_cr, .q_x, .q_y, .extreme_value, .bad_rectangle, .result_strobe
  );

endmodule

// ===== sv/rrq_checker.sv =====
// rrq_checker: port-level assertions for rect_range_extreme_query
// bound to the top level; depends on its ports only
module rrq_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_strobe,
  input logic bad_rectangle,
  input logic signed [31:0] extreme_value
);
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && bad_rectangle |-> extreme_value == 0) else $error("flag value");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe) else $error("strobe too long");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> !busy) else $error("busy after reset");
endmodule

bind rect_range_extreme_query rrq_checker u_rrq_checker (
  .clk, .rst, .start, .busy, .result_strobe, .bad_rectangle, .extreme_value
);

// ===== bench/rect_range_extreme_query_test.sv =====
// rect_range_extreme_query_test: self-checking bench for the rectangle max/min query block
// depends on rrq_pkg and rect_range_extreme_query; a grid model predicts every query
module rect_range_extreme_query_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rrq_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic             mode;
    logic [4:0]       r1, c1, r2, c2;
    logic signed [31:0] val;
  } grid_op_t;

  typedef struct {
    logic signed [31:0] value;
    logic               bad;
  } answer_t;

  logic clk = 0, rst = 1, start, mode, cfg_we;
  logic [4:0] top_row, left_col, bottom_row, right_col;
  logic signed [31:0] cell_value;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic busy, result_strobe, bad_rectangle;
  logic signed [31:0] extreme_value;

  rect_range_extreme_query u_dut (.*);

  always #6 clk = ~clk;

  // grid model and its settings
  logic signed [31:0] grid [32][32];
  bit loaded [32][32];
  bit use_max = 1;
  int n_rows = 32, n_cols = 32;

  grid_op_t pending[$];
  answer_t  answers[$];
  grid_op_t cur;
  int idle_pct = 0;
  int errors = 0, n_checked = 0, n_flagged = 0, n_loads = 0, cycles = 0;

  task automatic report(input string what, input logic signed [31:0] got, exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
  endtask

  function automatic answer_t rect_extreme(input grid_op_t q);
    answer_t a;
    a.value = 0;
    a.bad = (q.r1 > q.r2) || (q.c1 > q.c2) || (q.r2 >= n_rows) || (q.c2 >= n_cols);
    if (!a.bad) begin
      a.value = grid[q.r1][q.c1];
      for (int i = q.r1; i <= q.r2; i++)
        for (int j = q.c1; j <= q.c2; j++)
          if (use_max ? (grid[i][j] > a.value) : (grid[i][j] < a.value))
            a.value = grid[i][j];
    end
    return a;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        if (cur.mode == MODE_LOAD) begin
          grid[cur.r1][cur.c1] = cur.val;
          n_loads++;
        end else begin
          answers.push_back(rect_extreme(cur));
        end
      end
      if (!start || !busy) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur = pending.pop_front();
          mode <= cur.mode;
          top_row <= cur.r1;
          left_col <= cur.c1;
          bottom_row <= cur.r2;
          right_col <= cur.c2;
          cell_value <= cur.val;
          start <= 1;
        end else begin
          start <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (answers.size() == 0) begin
        report("unexpected result", extreme_value, 0);
      end else begin
        answer_t a;
        a = answers.pop_front();
        n_checked++;
        if (a.bad) n_flagged++;
        if (bad_rectangle !== a.bad) report("bad_rectangle", bad_rectangle, a.bad);
        if (extreme_value !== a.value) report("extreme_value", extreme_value, a.value);
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending.size() != 0 || start || answers.size() != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v[CFG_DATA_BITS-1:0];
    if (idx == REG_TAKE_MAX) use_max = v[0];
    else if (idx == REG_ROWS) n_rows = (v[5:0] == 0) ? 1 : (v[5:0] > 32) ? 32 : v[5:0];
    else if (idx == REG_COLS) n_cols = (v[5:0] == 0) ? 1 : (v[5:0] > 32) ? 32 : v[5:0];
  endtask

  task automatic setup(input int tm, input int rows_raw, input int cols_raw);
    wait_idle();
    write_reg(REG_TAKE_MAX, tm);
    write_reg(REG_ROWS, rows_raw);
    write_reg(REG_COLS, cols_raw);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic push_op(input logic m, input int r1, c1, r2, c2, input logic [31:0] v);
    grid_op_t g;
    g.mode = m; g.r1 = 5'(r1); g.c1 = 5'(c1); g.r2 = 5'(r2); g.c2 = 5'(c2); g.val = v;
    if (m == MODE_LOAD) loaded[r1][c1] = 1;
    pending.push_back(g);
  endtask

  task automatic fill_in_use();
    for (int i = 0; i < n_rows; i++)
      for (int j = 0; j < n_cols; j++)
        if (!loaded[i][j]) push_op(MODE_LOAD, i, j, $urandom_range(0, 31),
                                   $urandom_range(0, 31), $urandom());
  endtask

  task automatic random_ops(input int n);
    int r1, c1, load_pct;
    load_pct = (n_rows * n_cols > 256) ? 2 : 25;
    fill_in_use();
    for (int k = 0; k < n; k++) begin
      int p;
      p = $urandom_range(0, 99);
      if (p < load_pct) begin
        push_op(MODE_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom_range(0, 31), $urandom());
      end else if (p < load_pct + 12) begin
        push_op(MODE_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), $urandom_range(0, 31), $urandom());
      end else begin
        r1 = $urandom_range(0, n_rows - 1);
        c1 = $urandom_range(0, n_cols - 1);
        push_op(MODE_QUERY, r1, c1, $urandom_range(r1, n_rows - 1),
                $urandom_range(c1, n_cols - 1), $urandom());
      end
    end
  endtask

  initial begin
    logic [31:0] corner_vals [4];
    start <= 0; mode <= 0; top_row <= 0; left_col <= 0; bottom_row <= 0;
    right_col <= 0; cell_value <= 0; cfg_we <= 0; cfg_index <= 0; cfg_data <= 0;
    corner_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: extreme values on a 4 x 4 grid, each flag reason, both combines
    idle_pct = 16;
    write_reg(REG_SPARE, 5);
    setup(1, 4, 4);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        push_op(MODE_LOAD, i, j, 31, 31, corner_vals[(i + j) % 4]);
    push_op(MODE_QUERY, 0, 0, 3, 3, 0);
    push_op(MODE_QUERY, 0, 0, 0, 0, 0);
    push_op(MODE_QUERY, 3, 3, 3, 3, 0);
    push_op(MODE_QUERY, 2, 0, 1, 3, 0);
    push_op(MODE_QUERY, 0, 2, 3, 1, 0);
    push_op(MODE_QUERY, 0, 0, 4, 3, 0);
    push_op(MODE_QUERY, 0, 0, 3, 4, 0);
    push_op(MODE_QUERY, 31, 31, 31, 31, 32'hffff_ffff);
    setup(0, 4, 4);
    push_op(MODE_QUERY, 0, 0, 3, 3, 0);
    push_op(MODE_QUERY, 1, 1, 2, 3, 0);

    // random phases; rows 0 and cols above 32 exercise clamping
    setup(1, 0, 63);
    random_ops(90);
    setup(0, 32, 1);
    random_ops(90);
    idle_pct = 87;
    setup(1, 32, 8);
    random_ops(120);
    for (int k = 0; k < 2; k++) begin
      setup($urandom_range(0, 1), $urandom_range(1, 8), $urandom_range(1, 8));
      random_ops(60);
    end
    idle_pct = 0;
    for (int k = 0; k < 2; k++) begin
      setup($urandom_range(0, 1), $urandom_range(1, 12), $urandom_range(1, 12));
      random_ops(60);
    end
    setup(0, 1, 1);
    random_ops(40);

    wait_idle();
    repeat (50) @(posedge clk);
    $display("summary: %0d loads, %0d query results checked, %0d flagged rectangles",
             n_loads, n_checked, n_flagged);
    $display("grids from 1x1 to 32 rows or 32 columns under both max and min combining");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== rect_range_extreme_query.f =====
sv/rrq_pkg.sv
sv/rrq_ctrl.sv
sv/rrq_datapath.sv
sv/rect_range_extreme_query.sv
sv/rrq_checker.sv
bench/rect_range_extreme_query_test.sv
